>>> hdl/typec_cc_attach_detect_fsm_core_assert.svh
`ifndef TYPEC_CC_ATTACH_DETECT_FSM_CORE_ASSERT_SVH
`define TYPEC_CC_ATTACH_DETECT_FSM_CORE_ASSERT_SVH

// same-cycle implication, checking off during reset
`define TCAD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcad assertion failed");

// next-cycle implication, checking off during reset
`define TCAD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcad assertion failed");

`endif

>>> hdl/tcad_pkg.sv
package tcad_pkg;

   localparam logic [2:0] REQ_VBUS_ON       = 3'd0;
   localparam logic [2:0] REQ_VBUS_OFF      = 3'd1;
   localparam logic [2:0] REQ_DFP           = 3'd2;
   localparam logic [2:0] REQ_DRP           = 3'd3;
   localparam logic [2:0] REQ_TOGGLE_TICK   = 3'd4;
   localparam logic [2:0] REQ_DFP_MEASURED  = 3'd5;
   localparam logic [2:0] REQ_DRP_WAIT_DONE = 3'd6;
   localparam logic [2:0] REQ_LOCK_TIMEOUT  = 3'd7;

   localparam logic [1:0] CSR_DRP_TOGGLE_IN_PHY = 2'd0;
   localparam logic [1:0] CSR_PD_CAPABLE        = 2'd1;
   localparam logic [1:0] CSR_MAX_TOGGLES       = 2'd2;

   localparam logic [3:0] TOGGLE_LIMIT_DEFAULT = 4'd10;

   localparam logic [2:0] LEVEL_OPEN   = 3'd0;
   localparam logic [2:0] LEVEL_RA     = 3'd1;
   localparam logic [2:0] LEVEL_RD_1A5 = 3'd3;
   localparam logic [2:0] LEVEL_RD_3A0 = 3'd4;

   localparam logic [1:0] PHY_UNCHANGED = 2'd0;
   localparam logic [1:0] PHY_UFP       = 2'd1;
   localparam logic [1:0] PHY_DFP       = 2'd2;
   localparam logic [1:0] PHY_DRP       = 2'd3;

   localparam logic [1:0] CC_NONE = 2'd0;
   localparam logic [1:0] CC_PIN1 = 2'd1;
   localparam logic [1:0] CC_PIN2 = 2'd2;

   localparam logic [2:0] CABLE_NONE     = 3'd0;
   localparam logic [2:0] CABLE_USB      = 3'd1;
   localparam logic [2:0] CABLE_USB_HOST = 3'd2;
   localparam logic [2:0] CABLE_UFP      = 3'd3;
   localparam logic [2:0] CABLE_DFP      = 3'd4;

   localparam logic [1:0] PWR_NONE       = 2'd0;
   localparam logic [1:0] PWR_CONNECT    = 2'd1;
   localparam logic [1:0] PWR_DISCONNECT = 2'd2;

   localparam logic [11:0] MA_NONE = 12'd0;
   localparam logic [11:0] MA_1500 = 12'd1500;
   localparam logic [11:0] MA_3000 = 12'd3000;

   localparam logic [1:0] CRC_UNCHANGED = 2'd0;
   localparam logic [1:0] CRC_ENABLE    = 2'd1;
   localparam logic [1:0] CRC_DISABLE   = 2'd2;

   localparam logic [1:0] OTG_NONE   = 2'd0;
   localparam logic [1:0] OTG_ID     = 2'd1;
   localparam logic [1:0] OTG_DETACH = 2'd2;

   localparam logic [2:0] TMR_NONE         = 3'd0;
   localparam logic [2:0] TMR_START_TOGGLE = 3'd1;
   localparam logic [2:0] TMR_STOP_TOGGLE  = 3'd2;
   localparam logic [2:0] TMR_START_LOCK   = 3'd3;
   localparam logic [2:0] TMR_CANCEL_LOCK  = 3'd4;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] cc1_level;
      logic [2:0] cc2_level;
      logic       cc1_valid;
      logic       cc2_valid;
   } tcad_req_type;

   typedef struct packed {
      logic [2:0]  attach_state;
      logic [1:0]  phy_mode_cmd;
      logic        setup_cc;
      logic [1:0]  active_cc;
      logic [2:0]  cable_kind;
      logic        cable_on;
      logic [1:0]  power_event;
      logic [11:0] charge_ma;
      logic [1:0]  autocrc_cmd;
      logic [1:0]  otg_event;
      logic        request_measure;
      logic [2:0]  timer_cmd;
   } tcad_rsp_type;

   function automatic logic lv_open(input logic [2:0] lv);
      return lv == LEVEL_OPEN;
   endfunction

   function automatic logic lv_ra(input logic [2:0] lv);
      return lv == LEVEL_RA;
   endfunction

   function automatic logic lv_rd(input logic [2:0] lv);
      return lv > LEVEL_RA;
   endfunction

   // single pin showing rd while the other is open or ra
   function automatic logic [1:0] pick_cc(input logic [2:0] c1, input logic [2:0] c2);
      logic [1:0] use_cc;
      use_cc = CC_NONE;
      if (lv_rd(c1) && (lv_open(c2) || lv_ra(c2))) begin
         use_cc = CC_PIN1;
      end else if (lv_rd(c2) && (lv_open(c1) || lv_ra(c1))) begin
         use_cc = CC_PIN2;
      end
      return use_cc;
   endfunction

   function automatic logic [11:0] level_ma(input logic [2:0] lv);
      logic [11:0] ma;
      ma = MA_NONE;
      if (lv == LEVEL_RD_1A5) begin
         ma = MA_1500;
      end else if (lv == LEVEL_RD_3A0) begin
         ma = MA_3000;
      end
      return ma;
   endfunction

endpackage

>>> hdl/typec_cc_attach_detect_fsm_core.sv
// rsp_valid is registered and rises in the cycle after a req transfer
// throughput: one event per cycle while rsp_ready is high, set by the single result register
// a new event is taken while the pending result is being taken
// reset: synchronous, state unattached drp, vbus and toggle state cleared,
// max_toggles back to 10, other registers cleared except rsp_data_ff, which is not reset
`include "typec_cc_attach_detect_fsm_core_assert.svh"

module typec_cc_attach_detect_fsm_core
   import tcad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tcad_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tcad_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [3:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_UNATT_DRP = 3'd0,
      ST_UNATT_UFP = 3'd1,
      ST_UNATT_DFP = 3'd2,
      ST_DRP_WAIT  = 3'd3,
      ST_ATT_DFP   = 3'd4,
      ST_ATT_UFP   = 3'd5,
      ST_LOCK_UFP  = 3'd6
   } state_type;

   state_type    state_ff, state_in;
   logic         vbus_seen_ff, vbus_seen_in;
   logic [3:0]   toggle_count_ff, toggle_count_in;
   logic         toggle_active_ff, toggle_active_in;
   logic [1:0]   pending_cc_ff, pending_cc_in;
   logic         drp_toggle_in_phy_ff;
   logic         pd_capable_ff;
   logic [3:0]   max_toggles_ff;
   logic         rsp_valid_ff;
   tcad_rsp_type rsp_data_ff, rsp_data_in;
   logic         req_xfer;
   logic [1:0]   use_cc;
   logic [4:0]   tick_count;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign use_cc     = pick_cc(req_data.cc1_level, req_data.cc2_level);
   assign tick_count = {1'b0, toggle_count_ff} + 5'd1;

   always_comb begin
      state_in         = state_ff;
      vbus_seen_in     = vbus_seen_ff;
      toggle_count_in  = toggle_count_ff;
      toggle_active_in = toggle_active_ff;
      pending_cc_in    = pending_cc_ff;
      rsp_data_in      = '0;
      unique case (req_data.req_type)
         REQ_VBUS_ON: begin
            vbus_seen_in          = 1'b1;
            toggle_count_in       = '0;
            toggle_active_in      = 1'b0;
            rsp_data_in.timer_cmd = (state_ff == ST_LOCK_UFP) ? TMR_CANCEL_LOCK
                                                               : TMR_STOP_TOGGLE;
            if (state_ff != ST_ATT_DFP) begin
               if (!drp_toggle_in_phy_ff &&
                   (state_ff == ST_UNATT_DFP || state_ff == ST_UNATT_DRP)) begin
                  rsp_data_in.phy_mode_cmd = PHY_UFP;
               end
               if (lv_open(req_data.cc1_level) && lv_open(req_data.cc2_level)) begin
                  state_in                 = ST_UNATT_DRP;
                  rsp_data_in.phy_mode_cmd = PHY_DRP;
               end else if (use_cc != CC_NONE) begin
                  state_in                = ST_ATT_UFP;
                  rsp_data_in.setup_cc    = 1'b1;
                  rsp_data_in.active_cc   = use_cc;
                  rsp_data_in.cable_kind  = pd_capable_ff ? CABLE_UFP : CABLE_USB;
                  rsp_data_in.cable_on    = 1'b1;
                  rsp_data_in.autocrc_cmd = CRC_ENABLE;
                  rsp_data_in.power_event = PWR_CONNECT;
                  rsp_data_in.charge_ma   = level_ma((use_cc == CC_PIN1) ?
                                            req_data.cc1_level : req_data.cc2_level);
               end
            end
         end
         REQ_VBUS_OFF: begin
            vbus_seen_in            = 1'b0;
            toggle_count_in         = '0;
            rsp_data_in.setup_cc    = !drp_toggle_in_phy_ff;
            rsp_data_in.autocrc_cmd = CRC_DISABLE;
            if (state_ff == ST_ATT_UFP) begin
               state_in                = ST_UNATT_DRP;
               rsp_data_in.cable_kind  = pd_capable_ff ? CABLE_UFP : CABLE_USB;
               rsp_data_in.power_event = PWR_DISCONNECT;
            end else begin
               state_in                 = ST_LOCK_UFP;
               rsp_data_in.cable_kind   = pd_capable_ff ? CABLE_DFP : CABLE_USB_HOST;
               rsp_data_in.otg_event    = OTG_DETACH;
               rsp_data_in.timer_cmd    = TMR_START_LOCK;
               rsp_data_in.phy_mode_cmd = PHY_UFP;
            end
         end
         REQ_DFP: begin
            state_in                    = ST_UNATT_DFP;
            rsp_data_in.request_measure = !vbus_seen_ff;
         end
         REQ_DRP: begin
            if (!drp_toggle_in_phy_ff) begin
               state_in              = ST_UNATT_DRP;
               toggle_active_in      = 1'b1;
               rsp_data_in.timer_cmd = TMR_START_TOGGLE;
            end
         end
         REQ_TOGGLE_TICK: begin
            if (toggle_active_ff) begin
               if (tick_count > {1'b0, max_toggles_ff}) begin
                  toggle_count_in          = '0;
                  toggle_active_in         = 1'b0;
                  state_in                 = ST_UNATT_DRP;
                  rsp_data_in.timer_cmd    = TMR_STOP_TOGGLE;
                  rsp_data_in.phy_mode_cmd = PHY_DRP;
               end else begin
                  toggle_count_in = tick_count[3:0];
                  if (!vbus_seen_ff) begin
                     if (state_ff == ST_UNATT_DFP || state_ff == ST_UNATT_DRP) begin
                        state_in                 = ST_UNATT_UFP;
                        rsp_data_in.phy_mode_cmd = PHY_UFP;
                     end else if (state_ff == ST_UNATT_UFP) begin
                        state_in                    = ST_UNATT_DFP;
                        rsp_data_in.phy_mode_cmd    = PHY_DFP;
                        rsp_data_in.request_measure = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_DFP_MEASURED: begin
            if (state_ff == ST_UNATT_DFP && !vbus_seen_ff) begin
               if (req_data.cc1_valid && req_data.cc2_valid && use_cc != CC_NONE) begin
                  toggle_active_in      = 1'b0;
                  pending_cc_in         = use_cc;
                  state_in              = ST_DRP_WAIT;
                  rsp_data_in.timer_cmd = TMR_STOP_TOGGLE;
               end else if (req_data.cc1_valid && req_data.cc2_valid &&
                            ((lv_ra(req_data.cc1_level) && lv_ra(req_data.cc2_level)) ||
                             (lv_rd(req_data.cc1_level) && lv_rd(req_data.cc2_level)))) begin
                  state_in              = ST_ATT_DFP;
                  toggle_count_in       = '0;
                  toggle_active_in      = 1'b0;
                  rsp_data_in.timer_cmd = TMR_STOP_TOGGLE;
               end else if (!drp_toggle_in_phy_ff) begin
                  rsp_data_in.request_measure = 1'b1;
               end else begin
                  rsp_data_in.phy_mode_cmd = PHY_DRP;
               end
            end
         end
         REQ_DRP_WAIT_DONE: begin
            if (state_ff == ST_DRP_WAIT) begin
               state_in                = ST_ATT_DFP;
               toggle_count_in         = '0;
               rsp_data_in.setup_cc    = 1'b1;
               rsp_data_in.active_cc   = pending_cc_ff;
               rsp_data_in.cable_kind  = pd_capable_ff ? CABLE_DFP : CABLE_USB_HOST;
               rsp_data_in.cable_on    = 1'b1;
               rsp_data_in.autocrc_cmd = CRC_ENABLE;
               rsp_data_in.otg_event   = OTG_ID;
            end
         end
         REQ_LOCK_TIMEOUT: begin
            if (state_ff == ST_LOCK_UFP) begin
               state_in                 = ST_UNATT_DRP;
               rsp_data_in.phy_mode_cmd = PHY_DRP;
            end
         end
      endcase
      rsp_data_in.attach_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_UNATT_DRP;
         vbus_seen_ff         <= 1'b0;
         toggle_count_ff      <= '0;
         toggle_active_ff     <= 1'b0;
         pending_cc_ff        <= CC_NONE;
         drp_toggle_in_phy_ff <= 1'b0;
         pd_capable_ff        <= 1'b0;
         max_toggles_ff       <= TOGGLE_LIMIT_DEFAULT;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DRP_TOGGLE_IN_PHY: drp_toggle_in_phy_ff <= csr_wdata[0];
               CSR_PD_CAPABLE:        pd_capable_ff        <= csr_wdata[0];
               CSR_MAX_TOGGLES:       max_toggles_ff       <= csr_wdata;
               default: ;
            endcase
         end
         if (req_xfer) begin
            state_ff         <= state_in;
            vbus_seen_ff     <= vbus_seen_in;
            toggle_count_ff  <= toggle_count_in;
            toggle_active_ff <= toggle_active_in;
            pending_cc_ff    <= pending_cc_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `TCAD_ASSERT_NOW(a_stall_blocks_req, rsp_valid_ff && !rsp_ready, !req_ready)
   `TCAD_ASSERT_NOW(a_cc_needs_setup, rsp_valid_ff && rsp_data_ff.active_cc != CC_NONE,
                    rsp_data_ff.setup_cc)
   `TCAD_ASSERT_NOW(a_ma_needs_connect, rsp_valid_ff && rsp_data_ff.charge_ma != MA_NONE,
                    rsp_data_ff.power_event == PWR_CONNECT)
   `TCAD_ASSERT_NOW(a_state_matches_rsp, rsp_valid_ff,
                    rsp_data_ff.attach_state == state_ff)
   `TCAD_ASSERT_NEXT(a_vbus_off_locks,
                     req_xfer && req_data.req_type == REQ_VBUS_OFF && state_ff != ST_ATT_UFP,
                     state_ff == ST_LOCK_UFP && !vbus_seen_ff)

endmodule
